[hw/rtl/sbeq_pkg.sv]
package sbeq_pkg;

  localparam int unsigned NUM_BANDS_DEF = 10;
  localparam int unsigned NCOEF         = 5;
  localparam int unsigned MASK_BITS     = 10;
  localparam int unsigned SAMP_W        = 24;
  localparam int unsigned COEF_W        = 32;
  localparam int unsigned STATE_W       = 40;
  localparam int unsigned GAIN_W        = 24;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS = 2'd2;

  localparam logic [GAIN_W-1:0]    GAIN_RESET   = 24'd1048576;
  localparam logic [MASK_BITS-1:0] BYPASS_RESET = 10'h3FF;

  // coefficient selects
  localparam logic [2:0] SEL_B0 = 3'd0;
  localparam logic [2:0] SEL_B1 = 3'd1;
  localparam logic [2:0] SEL_B2 = 3'd2;
  localparam logic [2:0] SEL_A1 = 3'd3;
  localparam logic [2:0] SEL_A2 = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } ctl_state_t;

  // token handed from cell to cell
  typedef struct packed {
    logic                     vld;
    logic                     en;
    logic signed [SAMP_W-1:0] l;
    logic signed [SAMP_W-1:0] r;
  } tok_t;

  function automatic logic signed [SAMP_W-1:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[SAMP_W-1:0];
  endfunction

  function automatic logic signed [STATE_W-1:0] sat40(input logic signed [63:0] v);
    if (v > 64'sd549755813887) return 40'sh7FFFFFFFFF;
    if (v < -64'sd549755813888) return 40'sh8000000000;
    return v[STATE_W-1:0];
  endfunction

endpackage

[hw/rtl/sbeq_if.sv]
interface sbeq_in_if;
  import sbeq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [SAMP_W-1:0] left_in;
  logic signed [SAMP_W-1:0] right_in;
  logic [3:0]               band_index;
  logic [2:0]               coeff_select;
  logic signed [COEF_W-1:0] coeff_value;
  logic                     end_of_block;
  modport source (output valid, action, left_in, right_in, band_index, coeff_select,
                  coeff_value, end_of_block, input ready);
  modport sink   (input valid, action, left_in, right_in, band_index, coeff_select,
                  coeff_value, end_of_block, output ready);
endinterface

interface sbeq_out_if;
  import sbeq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [SAMP_W-1:0] left_out;
  logic signed [SAMP_W-1:0] right_out;
  logic                     last_frame;
  modport source (output valid, left_out, right_out, last_frame, input ready);
  modport sink   (input valid, left_out, right_out, last_frame, output ready);
endinterface

interface sbeq_cfg_if;
  import sbeq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/stereo_biquad_eq_cascade_core.sv]
// channel | dir | payload
// in_     | in  | action, left_in, right_in, band_index, coeff_select, coeff_value, end_of_block
// out_    | out | left_out, right_out, last_frame
// cfg_    | in  | index, data
// A frame passes the preamp cell (scaled in steps only when enabled), then each band:
// an active band takes the token and runs two channels of five steps on the cell's
// multipliers, while a bypassed band, or any band for a disabled frame, passes it on
// unchanged; then it goes into the output register. One item is in flight at a time.
// Synchronous active-low reset clears delay state, the FSM and valid flags, sets enable off,
// unity gain and all bands bypassed; coefficients are undefined until written. The result
// waits in the output register until taken, and the input stays stalled until then.
module stereo_biquad_eq_cascade_core #(
  parameter int unsigned NUM_BANDS = sbeq_pkg::NUM_BANDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sbeq_in_if.sink    in_ch,
  sbeq_out_if.source out_ch,
  sbeq_cfg_if.sink   cfg_ch
);
  import sbeq_pkg::*;

  ctl_state_t st_r, st_nxt;
  logic                  en_r;
  logic [GAIN_W-1:0]     gain_r;
  logic [MASK_BITS-1:0]  mask_r;
  logic                  last_r;
  logic                  ovld_r;
  logic signed [SAMP_W-1:0] ol_r, or_r;
  logic                  in_xfer, start;
  tok_t                  tok [NUM_BANDS+1];

  assign cfg_ch.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      gain_r <= GAIN_RESET;
      mask_r <= BYPASS_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_ENABLE: en_r   <= cfg_ch.data[0];
        REG_GAIN:   gain_r <= cfg_ch.data[GAIN_W-1:0];
        REG_BYPASS: mask_r <= cfg_ch.data[MASK_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign start       = in_xfer && !in_ch.action;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (start) st_nxt = ST_RUN;
      ST_RUN:  if (tok[NUM_BANDS].vld) st_nxt = ST_DONE;
      ST_DONE: if (out_ch.ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) last_r <= in_ch.end_of_block;
  end

  sbeq_front u_front (
    .clk, .rst_n, .start, .en(en_r), .gain(gain_r),
    .l(in_ch.left_in), .r(in_ch.right_in), .tok_o(tok[0])
  );

  for (genvar b = 0; b < NUM_BANDS; b++) begin : g_band
    logic byp;
    logic we;
    if (b < MASK_BITS) begin : g_m
      assign byp = mask_r[b];
    end else begin : g_n
      assign byp = 1'b1;
    end
    assign we = in_xfer && in_ch.action && (in_ch.band_index == 4'(b));
    sbeq_band_cell u_cell (
      .clk, .rst_n, .bypass(byp), .coef_we(we), .coef_sel(in_ch.coeff_select),
      .coef_val(in_ch.coeff_value), .tok_i(tok[b]), .tok_o(tok[b+1])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ovld_r <= 1'b0;
    else if (tok[NUM_BANDS].vld && st_r == ST_RUN) begin
      ovld_r <= 1'b1;
      ol_r   <= tok[NUM_BANDS].l;
      or_r   <= tok[NUM_BANDS].r;
    end else if (out_ch.ready) ovld_r <= 1'b0;
  end

  assign out_ch.valid      = ovld_r;
  assign out_ch.left_out   = ol_r;
  assign out_ch.right_out  = or_r;
  assign out_ch.last_frame = last_r;

endmodule

[hw/rtl/sbeq_band_cell.sv]
// One biquad band for both channels. Takes a token, works on it with its own multipliers,
// then hands the result to the next cell; a bypassed band or disabled token passes unchanged.
module sbeq_band_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               bypass,
  input  logic                               coef_we,
  input  logic [2:0]                         coef_sel,
  input  logic signed [sbeq_pkg::COEF_W-1:0] coef_val,
  input  sbeq_pkg::tok_t                     tok_i,
  output sbeq_pkg::tok_t                     tok_o
);
  import sbeq_pkg::*;

  logic signed [COEF_W-1:0]  c_r [NCOEF];
  logic signed [STATE_W-1:0] z1_r [2];
  logic signed [STATE_W-1:0] z2_r [2];
  logic [3:0]                ph_r;
  tok_t                      hold_r;
  tok_t                      out_r;
  logic signed [63:0]        pa_r, pb_r;
  logic signed [SAMP_W-1:0]  y_r;

  logic                      ch;
  logic signed [SAMP_W-1:0]  xs;
  logic signed [63:0]        acc;
  logic signed [63:0]        zsel1, zsel2;

  // coefficient store, written by the load path
  always_ff @(posedge clk) begin
    if (coef_we && coef_sel < 3'(NCOEF)) c_r[coef_sel] <= coef_val;
  end

  assign ch    = ph_r[3];
  assign xs    = ch ? hold_r.r : hold_r.l;
  assign zsel1 = 64'(z1_r[ch]);
  assign zsel2 = 64'(z2_r[ch]);
  assign acc   = ((pa_r + 64'sd524288) >>> 20) + zsel1;

  // phases per channel: 0 b0*x, 1 y, 2 b1*x and a1*y,
  // 3 z1 writeback with b2*x and a2*y, 4 z2 writeback and, after the right channel, hand-off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= '0;
      hold_r.vld <= 1'b0;
      out_r.vld  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        z1_r[i] <= '0;
        z2_r[i] <= '0;
      end
    end else begin
      out_r.vld <= 1'b0;
      if (!hold_r.vld) begin
        if (tok_i.vld) begin
          if (!tok_i.en) begin
            out_r <= tok_i;
          end else if (bypass) begin
            out_r <= tok_i;
            for (int i = 0; i < 2; i++) begin
              z1_r[i] <= '0;
              z2_r[i] <= '0;
            end
          end else begin
            hold_r <= tok_i;
            ph_r   <= '0;
          end
        end
      end else begin
        ph_r <= (ph_r[2:0] == 3'd4) ? 4'd8 : ph_r + 4'd1;
        unique case (ph_r[2:0])
          3'd0: pa_r <= 64'(c_r[SEL_B0]) * 64'(xs);
          3'd1: y_r <= sat24((acc + 64'sd128) >>> 8);
          3'd2: begin
            pa_r <= 64'(c_r[SEL_B1]) * 64'(xs);
            pb_r <= 64'(c_r[SEL_A1]) * 64'(y_r);
          end
          3'd3: begin
            z1_r[ch] <= sat40(((pa_r - pb_r + 64'sd524288) >>> 20) + zsel2);
            pa_r     <= 64'(c_r[SEL_B2]) * 64'(xs);
            pb_r     <= 64'(c_r[SEL_A2]) * 64'(y_r);
          end
          3'd4: begin
            z2_r[ch] <= sat40((pa_r - pb_r + 64'sd524288) >>> 20);
            if (ch) begin
              out_r      <= '{vld: 1'b1, en: hold_r.en, l: hold_r.l, r: y_r};
              hold_r.vld <= 1'b0;
            end else begin
              hold_r.l <= y_r;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign tok_o = out_r;

endmodule

[hw/rtl/sbeq_front.sv]
// Preamp cell: scales both channels when enabled and starts the token down the chain.
module sbeq_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               en,
  input  logic [sbeq_pkg::GAIN_W-1:0]        gain,
  input  logic signed [sbeq_pkg::SAMP_W-1:0] l,
  input  logic signed [sbeq_pkg::SAMP_W-1:0] r,
  output sbeq_pkg::tok_t                     tok_o
);
  import sbeq_pkg::*;

  tok_t               t_r;
  logic [1:0]         ph_r;
  logic signed [63:0] p_r;
  logic signed [SAMP_W-1:0] r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r.vld <= 1'b0;
      ph_r    <= '0;
    end else begin
      t_r.vld <= 1'b0;
      if (start) begin
        t_r.en <= en;
        t_r.l  <= l;
        r_r    <= r;
        t_r.r  <= r;
        if (en) ph_r <= 2'd1;
        else    t_r.vld <= 1'b1;
      end else if (ph_r == 2'd1) begin
        p_r  <= 64'(t_r.l) * $signed({40'd0, gain});
        ph_r <= 2'd2;
      end else if (ph_r == 2'd2) begin
        t_r.l <= sat24((p_r + 64'sd524288) >>> 20);
        p_r   <= 64'(r_r) * $signed({40'd0, gain});
        ph_r  <= 2'd3;
      end else if (ph_r == 2'd3) begin
        t_r.r   <= sat24((p_r + 64'sd524288) >>> 20);
        t_r.vld <= 1'b1;
        ph_r    <= 2'd0;
      end
    end
  end

  assign tok_o = t_r;
endmodule

[hw/rtl/sbeq_checker.sv]
module sbeq_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_action,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready
);
  // no new item while a result waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  // a frame never yields a result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_action) |=> !out_valid) else $error("result too early");
  // result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_cfg: assert property (@(posedge clk) cfg_ready) else $error("cfg stalled");
endmodule

bind stereo_biquad_eq_cascade_core sbeq_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_action(in_ch.action), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .cfg_ready(cfg_ch.ready)
);
